// ===== sv/key_to_escape_sequence_unit_assert.svh =====
// Assertion macros for the key to escape sequence unit.
// Included by the top level; simulation checks vanish when SYNTHESIS is set.
`ifndef KEY_TO_ESCAPE_SEQUENCE_UNIT_ASSERT_SVH
`define KEY_TO_ESCAPE_SEQUENCE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KTE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KTE_ASSERT(lbl, clk, rst, prop, msg)
`define KTE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/kte_pkg.sv =====
`timescale 1ns / 1ps
// Types, key codes and sequence builders for the key to escape sequence unit.
// No dependencies; used by kte_encode and key_to_escape_sequence_unit.
package kte_pkg;

   localparam int SEQ_MAX = 7;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_UPPER_O = 8'h4F;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;

   localparam logic [8:0] KEY_SPACE     = 9'd32;
   localparam logic [8:0] KEY_MINUS     = 9'd45;
   localparam logic [8:0] KEY_SLASH     = 9'd47;
   localparam logic [8:0] KEY_LETTER_A  = 9'd65;
   localparam logic [8:0] KEY_LETTER_Z  = 9'd90;
   localparam logic [8:0] KEY_LBRACKET  = 9'd91;
   localparam logic [8:0] KEY_BACKSLASH = 9'd92;
   localparam logic [8:0] KEY_RBRACKET  = 9'd93;
   localparam logic [8:0] KEY_ESCAPE    = 9'd256;
   localparam logic [8:0] KEY_ENTER     = 9'd257;
   localparam logic [8:0] KEY_TAB       = 9'd258;
   localparam logic [8:0] KEY_BACKSPACE = 9'd259;
   localparam logic [8:0] KEY_INSERT    = 9'd260;
   localparam logic [8:0] KEY_DELETE    = 9'd261;
   localparam logic [8:0] KEY_RIGHT     = 9'd262;
   localparam logic [8:0] KEY_LEFT      = 9'd263;
   localparam logic [8:0] KEY_DOWN      = 9'd264;
   localparam logic [8:0] KEY_UP        = 9'd265;
   localparam logic [8:0] KEY_PAGE_UP   = 9'd266;
   localparam logic [8:0] KEY_PAGE_DOWN = 9'd267;
   localparam logic [8:0] KEY_HOME      = 9'd268;
   localparam logic [8:0] KEY_END       = 9'd269;
   localparam logic [8:0] KEY_F1        = 9'd290;
   localparam logic [8:0] KEY_F2        = 9'd291;
   localparam logic [8:0] KEY_F3        = 9'd292;
   localparam logic [8:0] KEY_F4        = 9'd293;
   localparam logic [8:0] KEY_F5        = 9'd294;
   localparam logic [8:0] KEY_F12       = 9'd301;
   localparam logic [8:0] KEY_KP_ENTER  = 9'd335;

   localparam logic [7:0] PF_FINALS [4] = '{8'h50, 8'h51, 8'h52, 8'h53};
   localparam logic [1:0] FKEY_TENS [8] = '{2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2};
   localparam logic [3:0] FKEY_ONES [8] = '{4'd5, 4'd7, 4'd8, 4'd9, 4'd0, 4'd1, 4'd3, 4'd4};

   typedef struct packed {
      logic [SEQ_MAX-1:0][7:0] bytes;
      logic [2:0]              len;
   } seq_type;

   // ESC [ n ~ or ESC [ n ; m ~, where n has one or two digits.
   function automatic seq_type tilde_seq(input logic has_tens, input logic [1:0] tens,
                                         input logic [3:0] ones, input logic has_mod,
                                         input logic [7:0] mod_char);
      seq_type s;
      s = '0;
      s.bytes[0] = CH_ESC;
      s.bytes[1] = CH_LBRK;
      if (has_tens) begin
         s.bytes[2] = CH_ZERO + {6'd0, tens};
         s.bytes[3] = CH_ZERO + {4'd0, ones};
         if (has_mod) begin
            s.bytes[4] = CH_SEMI;
            s.bytes[5] = mod_char;
            s.bytes[6] = CH_TILDE;
            s.len = 3'd7;
         end else begin
            s.bytes[4] = CH_TILDE;
            s.len = 3'd5;
         end
      end else begin
         s.bytes[2] = CH_ZERO + {4'd0, ones};
         if (has_mod) begin
            s.bytes[3] = CH_SEMI;
            s.bytes[4] = mod_char;
            s.bytes[5] = CH_TILDE;
            s.len = 3'd6;
         end else begin
            s.bytes[3] = CH_TILDE;
            s.len = 3'd4;
         end
      end
      return s;
   endfunction

   // ESC intro X, or ESC [ 1 ; m X when a modifier is held.
   function automatic seq_type letter_seq(input logic [7:0] intro, input logic [7:0] fin,
                                          input logic has_mod, input logic [7:0] mod_char);
      seq_type s;
      s = '0;
      s.bytes[0] = CH_ESC;
      if (has_mod) begin
         s.bytes[1] = CH_LBRK;
         s.bytes[2] = CH_ONE;
         s.bytes[3] = CH_SEMI;
         s.bytes[4] = mod_char;
         s.bytes[5] = fin;
         s.len = 3'd6;
      end else begin
         s.bytes[1] = intro;
         s.bytes[2] = fin;
         s.len = 3'd3;
      end
      return s;
   endfunction

endpackage

// ===== sv/kte_encode.sv =====
`timescale 1ns / 1ps
// Combinational encoder from one key event to its byte sequence and length.
// Depends on kte_pkg for key codes, the sequence type and the builders.
module kte_encode import kte_pkg::*; (
   input  logic [8:0] key_code,
   input  logic       shift_held,
   input  logic       alt_held,
   input  logic       control_held,
   output seq_type    seq
);

   logic [3:0] mod;
   logic [7:0] mod_char;
   logic       has_mod;
   logic       ctrl_hit;
   logic [7:0] ctrl_code;
   logic [8:0] pf_off;
   logic [8:0] fk_off;

   assign mod      = 4'd1 + {3'd0, shift_held} + {2'd0, alt_held, 1'b0}
                     + {1'b0, control_held, 2'd0};
   assign mod_char = CH_ZERO + {4'd0, mod};
   assign has_mod  = shift_held | alt_held | control_held;
   assign pf_off   = key_code - KEY_F1;
   assign fk_off   = key_code - KEY_F5;

   always_comb begin
      ctrl_hit  = 1'b1;
      ctrl_code = 8'd0;
      if (key_code >= KEY_LETTER_A && key_code <= KEY_LETTER_Z) begin
         ctrl_code = key_code[7:0] - 8'd64;
      end else begin
         case (key_code)
            KEY_SPACE:     ctrl_code = 8'h00;
            KEY_SLASH:     ctrl_code = 8'h1F;
            KEY_MINUS:     ctrl_code = 8'h1F;
            KEY_LBRACKET:  ctrl_code = 8'h1B;
            KEY_BACKSLASH: ctrl_code = 8'h1C;
            KEY_RBRACKET:  ctrl_code = 8'h1D;
            default:       ctrl_hit  = 1'b0;
         endcase
      end
   end

   always_comb begin
      seq = '0;
      if (control_held && ctrl_hit) begin
         if (alt_held) begin
            seq.bytes[0] = CH_ESC;
            seq.bytes[1] = ctrl_code;
            seq.len      = 3'd2;
         end else begin
            seq.bytes[0] = ctrl_code;
            seq.len      = 3'd1;
         end
      end else begin
         case (key_code)
            KEY_ESCAPE: begin
               seq.bytes[0] = CH_ESC;
               seq.len      = 3'd1;
            end
            KEY_ENTER, KEY_KP_ENTER: begin
               seq.bytes[0] = CH_CR;
               seq.len      = 3'd1;
            end
            KEY_TAB: begin
               if (shift_held) begin
                  seq.bytes[0] = CH_ESC;
                  seq.bytes[1] = CH_LBRK;
                  seq.bytes[2] = CH_UPPER_Z;
                  seq.len      = 3'd3;
               end else begin
                  seq.bytes[0] = CH_TAB;
                  seq.len      = 3'd1;
               end
            end
            KEY_BACKSPACE: begin
               seq.bytes[0] = CH_DEL;
               seq.len      = 3'd1;
            end
            KEY_INSERT:    seq = tilde_seq(1'b0, 2'd0, 4'd2, has_mod, mod_char);
            KEY_DELETE:    seq = tilde_seq(1'b0, 2'd0, 4'd3, has_mod, mod_char);
            KEY_PAGE_UP:   seq = tilde_seq(1'b0, 2'd0, 4'd5, has_mod, mod_char);
            KEY_PAGE_DOWN: seq = tilde_seq(1'b0, 2'd0, 4'd6, has_mod, mod_char);
            KEY_RIGHT:     seq = letter_seq(CH_LBRK, 8'h43, has_mod, mod_char);
            KEY_LEFT:      seq = letter_seq(CH_LBRK, 8'h44, has_mod, mod_char);
            KEY_DOWN:      seq = letter_seq(CH_LBRK, 8'h42, has_mod, mod_char);
            KEY_UP:        seq = letter_seq(CH_LBRK, 8'h41, has_mod, mod_char);
            KEY_HOME:      seq = letter_seq(CH_LBRK, 8'h48, has_mod, mod_char);
            KEY_END:       seq = letter_seq(CH_LBRK, 8'h46, has_mod, mod_char);
            KEY_F1, KEY_F2, KEY_F3, KEY_F4: begin
               seq = letter_seq(CH_UPPER_O, PF_FINALS[pf_off[1:0]], has_mod, mod_char);
            end
            default: begin
               if (key_code >= KEY_F5 && key_code <= KEY_F12) begin
                  seq = tilde_seq(1'b1, FKEY_TENS[fk_off[2:0]], FKEY_ONES[fk_off[2:0]],
                                  has_mod, mod_char);
               end
            end
         endcase
      end
   end

endmodule

// ===== sv/key_to_escape_sequence_unit.sv =====
`timescale 1ns / 1ps
// Key event to xterm byte sequence unit. A key's beat is held in the input
// register, then encoded into the sequence register that shows its bytes.
// Throughput: one beat per cycle on the input side, bounded by the output,
// which sends one byte per cycle while rsp_ready is high; a key without bytes
// sends none. Reset is synchronous, active high, and empties both stages.
// Depends on kte_pkg, kte_encode and key_to_escape_sequence_unit_assert.svh.
`include "key_to_escape_sequence_unit_assert.svh"
module key_to_escape_sequence_unit import kte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [8:0] req_key_code,
   input  logic       req_shift_held,
   input  logic       req_alt_held,
   input  logic       req_control_held,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte
);

   logic       in_valid_ff, in_valid_in;
   logic [8:0] in_key_ff;
   logic       in_shift_ff, in_alt_ff, in_ctrl_ff;
   logic       seq_valid_ff, seq_valid_in;
   seq_type    seq_ff, seq_in;
   logic [2:0] idx_ff, idx_in;
   seq_type    enc;
   logic       req_fire, rsp_fire, seq_done, seq_free, in_move;

   kte_encode u_encode (
      .key_code     (in_key_ff),
      .shift_held   (in_shift_ff),
      .alt_held     (in_alt_ff),
      .control_held (in_ctrl_ff),
      .seq          (enc)
   );

   assign rsp_valid     = seq_valid_ff;
   assign rsp_out_byte  = seq_ff.bytes[idx_ff];
   assign rsp_last_byte = (idx_ff + 3'd1) == seq_ff.len;

   assign rsp_fire  = seq_valid_ff && rsp_ready;
   assign seq_done  = rsp_fire && rsp_last_byte;
   assign seq_free  = !seq_valid_ff || seq_done;
   assign in_move   = in_valid_ff && seq_free;
   assign req_ready = !in_valid_ff || seq_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      seq_valid_in = seq_valid_ff;
      seq_in       = seq_ff;
      idx_in       = idx_ff;
      if (in_move) begin
         seq_valid_in = enc.len != 3'd0;
         seq_in       = enc;
         idx_in       = 3'd0;
      end else if (seq_done) begin
         seq_valid_in = 1'b0;
      end else if (rsp_fire) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         seq_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         seq_valid_ff <= seq_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_key_ff   <= req_key_code;
         in_shift_ff <= req_shift_held;
         in_alt_ff   <= req_alt_held;
         in_ctrl_ff  <= req_control_held;
      end
      seq_ff <= seq_in;
   end

   `KTE_ASSERT(a_idx_in_range, clock, reset, seq_valid_ff |-> (idx_ff < seq_ff.len), "Byte index past sequence length.")
   `KTE_ASSERT(a_held_key_kept, clock, reset, (in_valid_ff && !seq_free) |=> in_valid_ff, "Waiting key event was lost.")
   `KTE_ASSERT(a_drain_empty, clock, reset, (seq_done && !in_valid_ff) |=> !rsp_valid, "Output stayed valid after the final byte.")
   `KTE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid && req_ready), "Unit not empty after reset.")

endmodule
